[src/qcbm_pkg.sv]
// ---------------------------------------------------------------------------
// qcbm_pkg - shared types and constants for the bracket matcher
// Character codes, register indexes, status codes, scanner state encodings
// and the bracket partner lookup.
// ---------------------------------------------------------------------------
`default_nettype none

package qcbm_pkg;

    localparam int INDEX_W = 20;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 8;

    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_STAR   = 8'h2A;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SCAN_BACKWARD    = 3'd0,
        REG_EXPECTED_PARTNER = 3'd1,
        REG_ALLOW_MISMATCH   = 3'd2,
        REG_ALLOW_EARLY_STOP = 3'd3,
        REG_C_COMMENTS_ON    = 3'd4
    } reg_idx_t;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_MISMATCH   = 2'd1,
        ST_UNBALANCED = 2'd2,
        ST_STOPPED    = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        QUOTE_NONE   = 3'b001,
        QUOTE_DOUBLE = 3'b010,
        QUOTE_SINGLE = 3'b100
    } quote_t;

    typedef enum logic [2:0] {
        CMT_UNKNOWN = 3'b001,
        CMT_INSIDE  = 3'b010,
        CMT_OUTSIDE = 3'b100
    } cmt_t;

    typedef struct packed {
        logic       scan_backward;
        logic [7:0] expected_partner;
        logic       allow_mismatch;
        logic       allow_early_stop;
        logic       c_comments_on;
    } cfg_t;

    typedef struct packed {
        logic [7:0] text_char;
        logic [7:0] char_before;
        logic [7:0] char_after;
        logic       odd_backslashes;
        logic       at_column_zero;
        logic       end_of_text;
    } item_t;

    typedef struct packed {
        logic    relevant;
        logic    fire;
        status_t status;
        logic    position_valid;
    } step_res_t;

    // {found, partner}; found is low when the character is no bracket
    function automatic logic [8:0] partner_of(input logic [7:0] ch);
        logic [8:0] res;
        unique case (ch)
            CH_LPAREN: res = {1'b1, CH_RPAREN};
            CH_RPAREN: res = {1'b1, CH_LPAREN};
            CH_LBRACE: res = {1'b1, CH_RBRACE};
            CH_RBRACE: res = {1'b1, CH_LBRACE};
            CH_LBRACK: res = {1'b1, CH_RBRACK};
            CH_RBRACK: res = {1'b1, CH_LBRACK};
            default:   res = 9'd0;
        endcase
        return res;
    endfunction

endpackage

`default_nettype wire

[src/qcbm_step.sv]
// ---------------------------------------------------------------------------
// qcbm_step - per-character scanner update
// Classifies one character and computes the next comment, quote and nesting
// state, and whether the character ends the search.
// ---------------------------------------------------------------------------
`default_nettype none

module qcbm_step #(
    parameter int MAX_NEST = 65535
) (
    input  var qcbm_pkg::cfg_t                    cfg,
    input  var qcbm_pkg::item_t                   item,
    input  wire logic [$clog2(MAX_NEST+1)-1:0]    count_in,
    input  var qcbm_pkg::quote_t                  quote_in,
    input  var qcbm_pkg::cmt_t                    cmt_in,
    input  wire logic [7:0]                       last_char_in,
    output logic [$clog2(MAX_NEST+1)-1:0]         count_out,
    output qcbm_pkg::quote_t                      quote_out,
    output qcbm_pkg::cmt_t                        cmt_out,
    output logic [7:0]                            last_char_out,
    output qcbm_pkg::step_res_t                   res
);

    localparam int NEST_W = $clog2(MAX_NEST + 1);
    localparam logic [NEST_W-1:0] NEST_MAX = NEST_W'(MAX_NEST);

    logic       is_open;
    logic       is_close;
    logic       is_dq;
    logic       is_sq;
    logic       is_slash;
    logic [8:0] partner;

    assign is_open  = (item.text_char == qcbm_pkg::CH_LPAREN) ||
                      (item.text_char == qcbm_pkg::CH_LBRACE) ||
                      (item.text_char == qcbm_pkg::CH_LBRACK);
    assign is_close = (item.text_char == qcbm_pkg::CH_RPAREN) ||
                      (item.text_char == qcbm_pkg::CH_RBRACE) ||
                      (item.text_char == qcbm_pkg::CH_RBRACK);
    assign is_dq    = item.text_char == qcbm_pkg::CH_DQUOTE;
    assign is_sq    = item.text_char == qcbm_pkg::CH_SQUOTE;
    assign is_slash = item.text_char == qcbm_pkg::CH_SLASH;
    assign partner  = qcbm_pkg::partner_of(cfg.expected_partner);

    always_comb begin
        logic             fwd;
        logic             marker;
        logic             up;
        logic             early;
        logic             ok;
        qcbm_pkg::cmt_t   cmt_new;
        qcbm_pkg::quote_t q_hit;

        fwd     = !cfg.scan_backward;
        marker  = 1'b0;
        up      = 1'b0;
        early   = 1'b0;
        ok      = 1'b0;
        cmt_new = cmt_in;
        q_hit   = is_dq ? qcbm_pkg::QUOTE_DOUBLE : qcbm_pkg::QUOTE_SINGLE;

        count_out          = count_in;
        quote_out          = quote_in;
        cmt_out            = cmt_in;
        last_char_out      = last_char_in;
        res.relevant       = is_open || is_close || is_dq ||
                             (cfg.c_comments_on && (is_slash || is_sq));
        res.fire           = 1'b0;
        res.status         = qcbm_pkg::ST_OK;
        res.position_valid = 1'b0;

        if (res.relevant && !item.odd_backslashes) begin
            last_char_out = item.text_char;

            if (quote_in == qcbm_pkg::QUOTE_NONE && is_slash) begin
                if (!item.at_column_zero && item.char_before == qcbm_pkg::CH_STAR) begin
                    cmt_new = fwd ? qcbm_pkg::CMT_OUTSIDE : qcbm_pkg::CMT_INSIDE;
                    marker  = 1'b1;
                end else if (item.char_after == qcbm_pkg::CH_STAR) begin
                    cmt_new = fwd ? qcbm_pkg::CMT_INSIDE : qcbm_pkg::CMT_OUTSIDE;
                    marker  = 1'b1;
                end
                if (marker && cmt_new == qcbm_pkg::CMT_OUTSIDE &&
                    cmt_in == qcbm_pkg::CMT_UNKNOWN) begin
                    count_out = '0;
                end
                cmt_out = cmt_new;
            end

            if (cmt_out != qcbm_pkg::CMT_INSIDE) begin
                if (is_dq || is_sq) begin
                    if (quote_in == q_hit) begin
                        quote_out = qcbm_pkg::QUOTE_NONE;
                    end else if (quote_in == qcbm_pkg::QUOTE_NONE) begin
                        quote_out = q_hit;
                    end
                end
                if (quote_out == qcbm_pkg::QUOTE_NONE && (is_open || is_close)) begin
                    up    = is_open ? fwd : !fwd;
                    early = is_open && item.at_column_zero && cfg.allow_early_stop;
                    if (up) begin
                        if (count_out != NEST_MAX) begin
                            count_out = count_out + 1'b1;
                        end
                    end else if (count_out == '0) begin
                        ok                 = partner[8] && (item.text_char == partner[7:0]);
                        early              = 1'b0;
                        res.fire           = 1'b1;
                        res.status         = ok ? qcbm_pkg::ST_OK : qcbm_pkg::ST_MISMATCH;
                        res.position_valid = ok || cfg.allow_mismatch;
                    end else begin
                        count_out = count_out - 1'b1;
                    end
                    if (early) begin
                        res.fire           = 1'b1;
                        res.status         = qcbm_pkg::ST_STOPPED;
                        res.position_valid = 1'b0;
                    end
                end
            end
        end
    end

endmodule

`default_nettype wire

[src/quote_comment_aware_bracket_matcher.sv]
// ---------------------------------------------------------------------------
// quote_comment_aware_bracket_matcher - streaming bracket matcher
// Scans text one character per word, tracking nesting, quotes and C-style
// comments, and reports where the current nesting level closes.
//
//   channel | ports      | direction | word
//   --------+------------+-----------+----------------------------------
//   input   | s_*        | in        | character with context flags
//   result  | m_*        | out       | status, found flag, index, char
//   config  | cfg_*      | in        | register write, index + data
//
// One character word per cycle while the result side does not stall; an
// accepted word waits in the input register, then its result goes to the result
// register. The nesting, quote and comment state loop closes through the
// combinational scanner step. A stalled result holds the input register; the
// input side keeps taking words until that register is full. Reset clears the
// search state and loads the register defaults.
// ---------------------------------------------------------------------------
`default_nettype none

module quote_comment_aware_bracket_matcher #(
    parameter int              MAX_NEST  = 65535,
    parameter longint unsigned MAX_ITEMS = 1048576
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,

    input  wire logic                              cfg_we,
    input  wire logic [qcbm_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [qcbm_pkg::CFG_DATA_W-1:0]   cfg_wdata,

    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire logic [7:0]                        s_text_char,
    input  wire logic [7:0]                        s_char_before,
    input  wire logic [7:0]                        s_char_after,
    input  wire logic                              s_odd_backslashes,
    input  wire logic                              s_at_column_zero,
    input  wire logic                              s_end_of_text,

    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output logic [1:0]                             m_match_status,
    output logic                                   m_position_valid,
    output logic [qcbm_pkg::INDEX_W-1:0]           m_match_index,
    output logic [7:0]                             m_final_char
);

    localparam int NEST_W = $clog2(MAX_NEST + 1);
    localparam int ITEM_W = $clog2(MAX_ITEMS);
    localparam logic [ITEM_W:0] ITEM_WRAP = (ITEM_W + 1)'(MAX_ITEMS);

    qcbm_pkg::cfg_t       cfg_reg;
    qcbm_pkg::item_t      in_item_reg;
    logic                 in_valid_reg;

    logic [NEST_W-1:0]    count_reg;
    qcbm_pkg::quote_t     quote_reg;
    qcbm_pkg::cmt_t       cmt_reg;
    logic [7:0]           last_char_reg;
    logic [ITEM_W-1:0]    item_cnt_reg;
    logic [ITEM_W-1:0]    last_hit_reg;

    logic                 m_valid_reg;
    qcbm_pkg::status_t    status_reg;
    logic                 pos_valid_reg;
    logic [qcbm_pkg::INDEX_W-1:0] index_reg;
    logic [7:0]           final_char_reg;

    logic [NEST_W-1:0]    count_next;
    qcbm_pkg::quote_t     quote_next;
    qcbm_pkg::cmt_t       cmt_next;
    logic [7:0]           last_char_next;
    logic [ITEM_W:0]      item_cnt_inc;
    logic [ITEM_W-1:0]    item_cnt_next;
    qcbm_pkg::step_res_t  step_res;

    logic                 advance;
    logic                 out_load;
    logic                 eot;
    logic [ITEM_W+qcbm_pkg::INDEX_W-1:0] cur_idx_wide;
    logic [ITEM_W+qcbm_pkg::INDEX_W-1:0] hit_idx_wide;

    qcbm_step #(
        .MAX_NEST (MAX_NEST)
    ) u_step (
        .cfg           (cfg_reg),
        .item          (in_item_reg),
        .count_in      (count_reg),
        .quote_in      (quote_reg),
        .cmt_in        (cmt_reg),
        .last_char_in  (last_char_reg),
        .count_out     (count_next),
        .quote_out     (quote_next),
        .cmt_out       (cmt_next),
        .last_char_out (last_char_next),
        .res           (step_res)
    );

    assign advance  = in_valid_reg && (!m_valid_reg || m_ready);
    assign eot      = in_item_reg.end_of_text;
    assign out_load = advance && (eot || step_res.fire);
    assign s_ready  = !in_valid_reg || advance;

    assign item_cnt_inc  = {1'b0, item_cnt_reg} + 1'b1;
    assign item_cnt_next = (item_cnt_inc == ITEM_WRAP) ? '0 : item_cnt_inc[ITEM_W-1:0];
    assign cur_idx_wide  = {{qcbm_pkg::INDEX_W{1'b0}}, item_cnt_reg};
    assign hit_idx_wide  = {{qcbm_pkg::INDEX_W{1'b0}}, last_hit_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.scan_backward    <= 1'b0;
            cfg_reg.expected_partner <= qcbm_pkg::CH_LPAREN;
            cfg_reg.allow_mismatch   <= 1'b0;
            cfg_reg.allow_early_stop <= 1'b0;
            cfg_reg.c_comments_on    <= 1'b1;
        end else if (cfg_we) begin
            unique case (qcbm_pkg::reg_idx_t'(cfg_index))
                qcbm_pkg::REG_SCAN_BACKWARD:    cfg_reg.scan_backward    <= cfg_wdata[0];
                qcbm_pkg::REG_EXPECTED_PARTNER: cfg_reg.expected_partner <= cfg_wdata;
                qcbm_pkg::REG_ALLOW_MISMATCH:   cfg_reg.allow_mismatch   <= cfg_wdata[0];
                qcbm_pkg::REG_ALLOW_EARLY_STOP: cfg_reg.allow_early_stop <= cfg_wdata[0];
                qcbm_pkg::REG_C_COMMENTS_ON:    cfg_reg.c_comments_on    <= cfg_wdata[0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_item_reg.text_char       <= s_text_char;
            in_item_reg.char_before     <= s_char_before;
            in_item_reg.char_after      <= s_char_after;
            in_item_reg.odd_backslashes <= s_odd_backslashes;
            in_item_reg.at_column_zero  <= s_at_column_zero;
            in_item_reg.end_of_text     <= s_end_of_text;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || out_load) begin
            count_reg     <= '0;
            quote_reg     <= qcbm_pkg::QUOTE_NONE;
            cmt_reg       <= qcbm_pkg::CMT_UNKNOWN;
            last_char_reg <= '0;
            item_cnt_reg  <= '0;
            last_hit_reg  <= '0;
        end else if (advance) begin
            count_reg     <= count_next;
            quote_reg     <= quote_next;
            cmt_reg       <= cmt_next;
            last_char_reg <= last_char_next;
            item_cnt_reg  <= item_cnt_next;
            if (step_res.relevant) begin
                last_hit_reg <= item_cnt_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            if (eot) begin
                status_reg     <= qcbm_pkg::ST_UNBALANCED;
                pos_valid_reg  <= 1'b0;
                index_reg      <= hit_idx_wide[qcbm_pkg::INDEX_W-1:0];
                final_char_reg <= last_char_reg;
            end else begin
                status_reg     <= step_res.status;
                pos_valid_reg  <= step_res.position_valid;
                index_reg      <= cur_idx_wide[qcbm_pkg::INDEX_W-1:0];
                final_char_reg <= in_item_reg.text_char;
            end
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_match_status   = status_reg;
    assign m_position_valid = pos_valid_reg;
    assign m_match_index    = index_reg;
    assign m_final_char     = final_char_reg;

    a_found_only_ok_or_mismatch: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_position_valid |->
            (m_match_status == qcbm_pkg::ST_OK) || (m_match_status == qcbm_pkg::ST_MISMATCH))
        else $error("position flagged on unbalanced or stopped result");

    a_ok_is_found: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_match_status == qcbm_pkg::ST_OK) |-> m_position_valid)
        else $error("ok result without position");

    a_clear_after_result: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |=> (count_reg == '0) && (item_cnt_reg == '0) &&
                     (quote_reg == qcbm_pkg::QUOTE_NONE) && m_valid_reg)
        else $error("search state not cleared after result");

endmodule

`default_nettype wire
